>>> rtl/core/psfd_pkg.sv
// Package for the per-source flood detector: table sizing, entry layout,
// register map and slot hash. No dependencies.
package psfd_pkg;

	localparam int TABLE_ENTRIES = 1024;
	// hash table has twice the tracked capacity, so a probe always finds a free slot
	localparam int SLOT_COUNT    = 2 * TABLE_ENTRIES;
	localparam int SLOT_BITS     = $clog2(SLOT_COUNT);
	localparam int OCC_BITS      = $clog2(TABLE_ENTRIES) + 1;

	localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;

	localparam logic [63:0] WINDOW_RESET    = 64'd1000000000;
	localparam logic [31:0] THRESHOLD_RESET = 32'd100;

	// register select: paddr bit 3
	localparam logic REG_WINDOW    = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] count;
		logic [63:0] start;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	function automatic logic [SLOT_BITS-1:0] slot_hash(input logic [31:0] key);
		logic [SLOT_BITS-1:0] h;
		h = '0;
		for (int i = 0; i < 32; i++) begin
			h[i % SLOT_BITS] = h[i % SLOT_BITS] ^ key[i];
		end
		return h;
	endfunction

endpackage

>>> rtl/core/psfd_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module psfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/per_source_flood_detector_unit.sv
// Per-source flood detector, one frame in flight: an ignored frame passes idle and filter;
// a tracked frame passes idle, filter, probe (P = extra hash probes, linear probing in a
// 2x-sized table, one RAM read per cycle) and update or miss. The next frame is taken in idle
// once the result is registered; a stalled result holds that frame in its last state.
// After reset a clearing pass writes all 2*TABLE_ENTRIES slots, one per cycle;
// frames are held off until it ends. Registers reset at once. Depends on psfd_pkg, psfd_ram.
module per_source_flood_detector_unit
	import psfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// frame input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] frame_length,
	input  logic [15:0] ether_type,
	input  logic [31:0] source_address,
	input  logic [63:0] timestamp_ns,
	// result
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ignored,
	output logic        new_source,
	output logic        not_tracked,
	output logic        alarm,
	output logic [31:0] alarm_count
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FILTER,
		S_PROBE,
		S_UPDATE,
		S_MISS
	} state_t;

	state_t state_q;

	logic [63:0] window_q;
	logic [31:0] threshold_q;

	logic [15:0] len_q;
	logic [15:0] etype_q;
	logic [31:0] src_q;
	logic [63:0] now_q;

	logic [SLOT_BITS-1:0] probe_q;
	logic [SLOT_BITS:0]   clr_q;
	logic [OCC_BITS-1:0]  occ_q;
	logic [63:0]          elapsed_q;
	logic [31:0]          count_q;

	logic        out_valid_q;
	logic        ignored_q;
	logic        new_source_q;
	logic        not_tracked_q;
	logic        alarm_q;
	logic [31:0] alarm_count_q;

	logic                 rd_en;
	logic [SLOT_BITS-1:0] rd_addr;
	entry_t               rd_entry;
	logic                 wr_en;
	logic [SLOT_BITS-1:0] wr_addr;
	entry_t               wr_entry;

	logic can_finish;
	logic pass;
	logic hit;
	logic close_win;
	logic table_full;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3])
			REG_WINDOW:    prdata = window_q;
			REG_THRESHOLD: prdata = {32'd0, threshold_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RESET;
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_WINDOW) begin
				window_q <= pwdata;
			end else begin
				threshold_q <= pwdata[31:0];
			end
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign can_finish = !out_valid_q || out_ready;
	assign pass       = (len_q >= MIN_FRAME_BYTES) && (etype_q == ETHERTYPE_IPV4);
	assign hit        = rd_entry.valid && (rd_entry.key == src_q);
	assign close_win  = (elapsed_q >= window_q);
	assign table_full = (occ_q == OCC_BITS'(TABLE_ENTRIES));

	psfd_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(SLOT_COUNT)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = probe_q + SLOT_BITS'(1);
		if (state_q == S_FILTER && pass) begin
			rd_en   = 1'b1;
			rd_addr = slot_hash(src_q);
		end else if (state_q == S_PROBE && !hit && rd_entry.valid) begin
			rd_en = 1'b1;
		end
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = probe_q;
		wr_entry = '{valid: 1'b1, key: src_q, count: 32'd1, start: now_q};
		case (state_q)
			S_CLEAR: begin
				wr_en    = 1'b1;
				wr_addr  = clr_q[SLOT_BITS-1:0];
				wr_entry = '0;
			end
			S_UPDATE: begin
				wr_en = can_finish;
				if (!close_win) begin
					wr_entry.start = now_q - elapsed_q;
					wr_entry.count = (count_q == 32'hFFFF_FFFF) ? count_q : count_q + 32'd1;
				end
			end
			S_MISS: begin
				wr_en = can_finish && !table_full;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			occ_q         <= '0;
			probe_q       <= '0;
			out_valid_q   <= 1'b0;
			ignored_q     <= 1'b0;
			new_source_q  <= 1'b0;
			not_tracked_q <= 1'b0;
			alarm_q       <= 1'b0;
			alarm_count_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_en) begin
				probe_q <= rd_addr;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + (SLOT_BITS+1)'(1);
					if (clr_q == (SLOT_BITS+1)'(SLOT_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FILTER;
					end
				end
				S_FILTER: begin
					if (pass) begin
						state_q <= S_PROBE;
					end else if (can_finish) begin
						out_valid_q   <= 1'b1;
						ignored_q     <= 1'b1;
						new_source_q  <= 1'b0;
						not_tracked_q <= 1'b0;
						alarm_q       <= 1'b0;
						alarm_count_q <= '0;
						state_q       <= S_IDLE;
					end
				end
				S_PROBE: begin
					if (hit) begin
						state_q <= S_UPDATE;
					end else if (!rd_entry.valid) begin
						state_q <= S_MISS;
					end
				end
				S_UPDATE: begin
					if (can_finish) begin
						out_valid_q   <= 1'b1;
						ignored_q     <= 1'b0;
						new_source_q  <= 1'b0;
						not_tracked_q <= 1'b0;
						alarm_q       <= close_win && (count_q >= threshold_q);
						alarm_count_q <= (close_win && (count_q >= threshold_q)) ? count_q : '0;
						state_q       <= S_IDLE;
					end
				end
				S_MISS: begin
					if (can_finish) begin
						out_valid_q   <= 1'b1;
						ignored_q     <= 1'b0;
						new_source_q  <= !table_full;
						not_tracked_q <= table_full;
						alarm_q       <= 1'b0;
						alarm_count_q <= '0;
						if (!table_full) begin
							occ_q <= occ_q + OCC_BITS'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload capture, and elapsed time and count of the hit entry
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			len_q   <= frame_length;
			etype_q <= ether_type;
			src_q   <= source_address;
			now_q   <= timestamp_ns;
		end
		if (state_q == S_PROBE && hit) begin
			elapsed_q <= now_q - rd_entry.start;
			count_q   <= rd_entry.count;
		end
	end

	assign out_valid   = out_valid_q;
	assign ignored     = ignored_q;
	assign new_source  = new_source_q;
	assign not_tracked = not_tracked_q;
	assign alarm       = alarm_q;
	assign alarm_count = alarm_count_q;

endmodule
